>>> rtl/tcpr_pkg.sv
// Package: constants, types and state encoding for the TCP reassembly flow table.
`timescale 1ns / 1ps
package tcpr_pkg;
    localparam int MaxFlows    = 64;
    localparam int SlotW       = 6;
    localparam int CntW        = 7;
    localparam int BufferBytes = 4096;
    localparam int LenW        = 12;
    localparam int KeyW        = 96;

    localparam logic [15:0] TimeoutReset = 16'd30;

    localparam logic [1:0] StAppended = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StDropped  = 2'd2;

    localparam logic CmdHeader  = 1'b0;
    localparam logic CmdPayload = 1'b1;

    localparam logic [7:0] ChCr = 8'd13;
    localparam logic [7:0] ChLf = 8'd10;
    localparam logic [2:0] MatchFound = 3'd4;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_CLOSE,
        t_ST_SCAN,
        t_ST_DECIDE,
        t_ST_HDRRD,
        t_ST_HDRWR,
        t_ST_BYTE,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]     exp_seq;
        logic [LenW-1:0] held;
        logic [2:0]      prog;
        logic            zero;
    } t_slot;
endpackage

>>> rtl/tcp_inorder_reassembly_flow_table.sv
// Top level: TCP in-order reassembly flow table with memory-held per-slot state.
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_idle_timeout
// in        in   i_valid/o_ready           cmd, 4-tuple, seq, len, time, byte, last
// out       out  o_valid/i_ready           status, slot, lengths, done
// Header beat: a close step, then a read and a compare for each used slot scanned,
// then a read-modify-write of a matched slot, or for a new or reused one the steps
// end of scan, allocate, read and write; a full-table drop returns from the allocate step.
// Payload beat: read slot record, update, write back; a stray byte goes straight back to idle.
// A full output register stalls acceptance until the result is taken.
// Reset clears control and the valid bits of the per-slot buffer state; no clear pass.
module tcp_inorder_reassembly_flow_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_idle_timeout,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_seq_num,
    input  logic [11:0] i_seg_len,
    input  logic [31:0] i_now_sec,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_flow_slot,
    output logic [11:0] o_buffered_len,
    output logic        o_message_done,
    output logic [11:0] o_message_len
);
    localparam int SW = tcpr_pkg::SlotW;
    localparam int LW = tcpr_pkg::LenW;

    // memories: key, last-seen time, slot record
    logic [tcpr_pkg::KeyW-1:0] m_key  [tcpr_pkg::MaxFlows];
    logic [31:0]               m_time [tcpr_pkg::MaxFlows];
    tcpr_pkg::t_slot           m_slot [tcpr_pkg::MaxFlows];
    // buffer-state valid bits: an invalid slot reads held/prog/zero as zero
    logic [tcpr_pkg::MaxFlows-1:0] r_sv, n_sv;

    logic [tcpr_pkg::KeyW-1:0] r_key_q;
    logic [31:0]               r_time_q;
    tcpr_pkg::t_slot           r_slot_q;

    tcpr_pkg::t_state r_st, n_st;
    logic [15:0]   r_tmo;
    logic [tcpr_pkg::CntW-1:0] r_used, n_used;
    logic          r_open, n_open;
    logic [SW-1:0] r_cslot, n_cslot;
    logic [LW-1:0] r_rem, n_rem;
    logic [tcpr_pkg::CntW-1:0] r_idx, n_idx;
    logic          r_hidle, n_hidle;
    logic [SW-1:0] r_idle, n_idle;
    logic          r_match, n_match;
    logic [SW-1:0] r_ws, n_ws;

    // latched input beat
    logic          r_cmd;
    logic [tcpr_pkg::KeyW-1:0] r_ikey;
    logic [31:0]   r_seq, r_now;
    logic [LW-1:0] r_len;
    logic [7:0]    r_byte;
    logic          r_last;

    logic          r_ov;
    logic [1:0]    r_ostat, n_ostat;
    logic [SW-1:0] r_oslot, n_oslot;
    logic [LW-1:0] r_oblen, n_oblen;
    logic          r_odone, n_odone;
    logic [LW-1:0] r_omlen, n_omlen;
    logic          n_ov_set;

    // memory port control
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          key_we, slot_we;
    tcpr_pkg::t_slot wr_slot;

    tcpr_pkg::t_slot cur;
    logic accept;
    logic [31:0] idle_dt;

    assign o_cfg_ready = (r_st == tcpr_pkg::t_ST_IDLE);
    assign o_ready = (r_st == tcpr_pkg::t_ST_IDLE) && !r_ov;
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_q  <= m_key[rd_addr];
            r_time_q <= m_time[rd_addr];
            r_slot_q <= m_slot[rd_addr];
        end
        if (key_we) begin
            m_key[r_ws]  <= r_ikey;
        end
        if (slot_we) begin
            m_slot[r_ws] <= wr_slot;
        end
        if (key_we || (slot_we && r_st == tcpr_pkg::t_ST_HDRWR)) begin
            m_time[r_ws] <= r_now;
        end
    end

    // slot record seen through the valid bit (seq/key/time are not masked by it)
    always_comb begin
        cur = r_slot_q;
        if (!r_sv[r_ws]) begin
            cur.held = '0;
            cur.prog = '0;
            cur.zero = 1'b0;
        end
    end

    assign idle_dt = r_now - r_time_q;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            tcpr_pkg::t_ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == tcpr_pkg::CmdPayload) begin
                        n_st = r_open ? tcpr_pkg::t_ST_HDRRD : tcpr_pkg::t_ST_IDLE;
                    end else begin
                        n_st = tcpr_pkg::t_ST_CLOSE;
                    end
                end
            end
            tcpr_pkg::t_ST_CLOSE: n_st = tcpr_pkg::t_ST_SCAN;
            tcpr_pkg::t_ST_SCAN:
                n_st = (r_idx < r_used) ? tcpr_pkg::t_ST_DECIDE : tcpr_pkg::t_ST_OUT;
            tcpr_pkg::t_ST_DECIDE: begin
                if (r_ikey == r_key_q) n_st = tcpr_pkg::t_ST_HDRRD;
                else n_st = tcpr_pkg::t_ST_SCAN;
            end
            tcpr_pkg::t_ST_HDRRD:
                n_st = (r_cmd == tcpr_pkg::CmdPayload) ? tcpr_pkg::t_ST_BYTE
                                                       : tcpr_pkg::t_ST_HDRWR;
            tcpr_pkg::t_ST_HDRWR: n_st = tcpr_pkg::t_ST_IDLE;
            tcpr_pkg::t_ST_BYTE: n_st = tcpr_pkg::t_ST_IDLE;
            tcpr_pkg::t_ST_OUT: n_st = tcpr_pkg::t_ST_HDRRD;
            default: n_st = tcpr_pkg::t_ST_IDLE;
        endcase
        // no slot at all: go back idle from OUT
        if (r_st == tcpr_pkg::t_ST_OUT && !n_match) n_st = tcpr_pkg::t_ST_IDLE;
    end

    // datapath / outputs
    always_comb begin
        logic [LW:0] sum;
        logic [2:0]  p;
        logic        hit;
        rd_en = 1'b0;
        rd_addr = r_ws;
        key_we = 1'b0;
        slot_we = 1'b0;
        wr_slot = cur;
        n_sv = r_sv;
        n_used = r_used;
        n_open = r_open;
        n_cslot = r_cslot;
        n_rem = r_rem;
        n_idx = r_idx;
        n_hidle = r_hidle;
        n_idle = r_idle;
        n_match = r_match;
        n_ws = r_ws;
        n_ov_set = 1'b0;
        n_ostat = r_ostat;
        n_oslot = r_oslot;
        n_oblen = r_oblen;
        n_odone = r_odone;
        n_omlen = r_omlen;
        sum = '0;
        p = cur.prog;
        hit = 1'b0;
        case (r_st)
            tcpr_pkg::t_ST_IDLE: begin
                n_ws = r_cslot;
                n_idx = '0;
                n_hidle = 1'b0;
                n_match = 1'b0;
                // open segment: its record is needed by a byte or by the close
                if (accept && r_open) begin
                    rd_en = 1'b1;
                    rd_addr = r_cslot;
                end
            end
            tcpr_pkg::t_ST_CLOSE: begin
                // abandoned segment: found terminator clears the buffer
                if (r_open) begin
                    n_open = 1'b0;
                    if (r_sv[r_cslot] && r_slot_q.prog == tcpr_pkg::MatchFound) begin
                        n_sv[r_cslot] = 1'b0;
                    end
                end
            end
            tcpr_pkg::t_ST_SCAN: begin
                if (r_idx < r_used) begin
                    rd_en = 1'b1;
                    rd_addr = r_idx[SW-1:0];
                end
            end
            tcpr_pkg::t_ST_DECIDE: begin
                if (r_ikey == r_key_q) begin
                    n_match = 1'b1;
                    n_hidle = 1'b0;
                    n_ws = r_idx[SW-1:0];
                    rd_en = 1'b1;
                    rd_addr = r_idx[SW-1:0];
                end else begin
                    if (idle_dt > {16'd0, r_tmo}) begin
                        n_hidle = 1'b1;
                        n_idle = r_idx[SW-1:0];
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            tcpr_pkg::t_ST_OUT: begin
                // no match: allocate
                if (r_used < tcpr_pkg::CntW'(tcpr_pkg::MaxFlows)) begin
                    n_ws = r_used[SW-1:0];
                    n_used = r_used + 1'b1;
                    n_match = 1'b1;
                    hit = 1'b1;
                end else if (r_hidle) begin
                    n_ws = r_idle;
                    n_match = 1'b1;
                    hit = 1'b1;
                end else begin
                    n_ov_set = 1'b1;
                    n_ostat = tcpr_pkg::StFull;
                    n_oslot = '0;
                    n_oblen = '0;
                    n_odone = 1'b0;
                    n_omlen = '0;
                end
                if (hit) begin
                    // fresh slot: write key, clear buffer, seq seeded below
                    n_sv[n_ws] = 1'b0;
                    rd_en = 1'b1;
                    rd_addr = n_ws;
                end
                // from here on r_hidle marks a new or reused slot
                n_hidle = hit;
            end
            tcpr_pkg::t_ST_HDRWR: begin
                // new or reused slot: fresh key, seq and buffer
                if (r_hidle) begin
                    wr_slot.exp_seq = r_seq;
                    wr_slot.held = '0;
                    wr_slot.prog = '0;
                    wr_slot.zero = 1'b0;
                    key_we = 1'b1;
                end
                sum = {1'b0, wr_slot.held} + {1'b0, r_len};
                slot_we = 1'b1;
                n_sv[r_ws] = 1'b1;
                n_ov_set = 1'b1;
                n_oslot = r_ws;
                n_odone = 1'b0;
                n_omlen = '0;
                if (r_seq == wr_slot.exp_seq && !sum[LW]) begin
                    wr_slot.exp_seq = r_seq + {20'd0, r_len};
                    if (r_len == '0) begin
                        n_ostat = tcpr_pkg::StAppended;
                        if (wr_slot.prog == tcpr_pkg::MatchFound) begin
                            n_odone = 1'b1;
                            n_omlen = wr_slot.held;
                            n_oblen = '0;
                            wr_slot.held = '0;
                            wr_slot.prog = '0;
                            wr_slot.zero = 1'b0;
                        end else begin
                            n_oblen = wr_slot.held;
                        end
                    end else begin
                        n_ov_set = 1'b0;
                        n_open = 1'b1;
                        n_cslot = r_ws;
                        n_rem = r_len;
                    end
                end else begin
                    n_ostat = tcpr_pkg::StDropped;
                    n_oblen = wr_slot.held;
                end
            end
            tcpr_pkg::t_ST_BYTE: begin
                if (!cur.held[LW-1] || cur.held != '1) begin
                    wr_slot.held = cur.held + 1'b1;
                    if (!cur.zero && cur.prog != tcpr_pkg::MatchFound) begin
                        if (r_byte == 8'd0) wr_slot.zero = 1'b1;
                        else begin
                            if ((p == 3'd0 || p == 3'd2) && r_byte == tcpr_pkg::ChCr) p = p + 1'b1;
                            else if ((p == 3'd1 || p == 3'd3) && r_byte == tcpr_pkg::ChLf)
                                p = p + 1'b1;
                            else if (r_byte == tcpr_pkg::ChCr) p = 3'd1;
                            else p = 3'd0;
                            wr_slot.prog = p;
                        end
                    end
                end
                slot_we = 1'b1;
                n_sv[r_ws] = 1'b1;
                n_rem = r_rem - 1'b1;
                if (r_rem == 12'd1 || r_last) begin
                    n_open = 1'b0;
                    n_ov_set = 1'b1;
                    n_ostat = tcpr_pkg::StAppended;
                    n_oslot = r_ws;
                    if (wr_slot.prog == tcpr_pkg::MatchFound) begin
                        n_odone = 1'b1;
                        n_omlen = wr_slot.held;
                        n_oblen = '0;
                        n_sv[r_ws] = 1'b0;
                    end else begin
                        n_odone = 1'b0;
                        n_omlen = '0;
                        n_oblen = wr_slot.held;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tcpr_pkg::t_ST_IDLE;
            r_tmo <= tcpr_pkg::TimeoutReset;
            r_used <= '0;
            r_open <= 1'b0;
            r_sv <= '0;
            r_ov <= 1'b0;
            r_idx <= '0;
            r_hidle <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) r_tmo <= i_cfg_idle_timeout;
            r_used <= n_used;
            r_open <= n_open;
            r_sv <= n_sv;
            r_idx <= (r_st == tcpr_pkg::t_ST_OUT) ? r_used : n_idx;
            r_hidle <= n_hidle;
            r_match <= n_match;
            if (n_ov_set) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cslot <= n_cslot;
        r_rem <= n_rem;
        r_idle <= n_idle;
        r_ws <= n_ws;
        r_ostat <= n_ostat;
        r_oslot <= n_oslot;
        r_oblen <= n_oblen;
        r_odone <= n_odone;
        r_omlen <= n_omlen;
        if (accept) begin
            r_cmd <= i_cmd;
            r_ikey <= {i_src_addr, i_dst_addr, i_src_port, i_dst_port};
            r_seq <= i_seq_num;
            r_len <= i_seg_len;
            r_now <= i_now_sec;
            r_byte <= i_payload_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_ostat;
    assign o_flow_slot = r_oslot;
    assign o_buffered_len = r_oblen;
    assign o_message_done = r_odone;
    assign o_message_len = r_omlen;

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= tcpr_pkg::CntW'(tcpr_pkg::MaxFlows)) else $error("slot count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != tcpr_pkg::t_ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_done) |-> (o_buffered_len == '0)) else $error("done with data");
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == tcpr_pkg::StFull) |-> (o_flow_slot == '0))
        else $error("full drop slot");
endmodule
